FILE: rtl/ep2t_pkg.sv
package ep2t_pkg;

    localparam int TAB_LEN = 24;
    localparam int AW = 34;  // CORDIC datapath width, Q.30 plus headroom

    localparam logic signed [AW-1:0] Q30_ONE     = 34'sd1073741824;
    localparam logic signed [AW-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [AW-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [AW-1:0] CORDIC_GAIN = 34'sd652032874;

    // Pose after the CORDIC stage: sines and cosines in Q.30, position as given.
    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] cx;
        logic signed [31:0] sy;
        logic signed [31:0] cy;
        logic signed [31:0] sz;
        logic signed [31:0] cz;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
    } trig_t;

    function automatic logic signed [AW-1:0] atan_lut(input logic [4:0] i);
        logic signed [AW-1:0] r;
        case (i)
            5'd0:  r = 34'sd843314856;
            5'd1:  r = 34'sd497837829;
            5'd2:  r = 34'sd263043836;
            5'd3:  r = 34'sd133525158;
            5'd4:  r = 34'sd67021686;
            5'd5:  r = 34'sd33543515;
            5'd6:  r = 34'sd16775850;
            5'd7:  r = 34'sd8388437;
            5'd8:  r = 34'sd4194282;
            5'd9:  r = 34'sd2097149;
            5'd10: r = 34'sd1048575;
            5'd11: r = 34'sd524287;
            5'd12: r = 34'sd262143;
            5'd13: r = 34'sd131071;
            5'd14: r = 34'sd65535;
            5'd15: r = 34'sd32767;
            5'd16: r = 34'sd16383;
            5'd17: r = 34'sd8191;
            5'd18: r = 34'sd4095;
            5'd19: r = 34'sd2047;
            5'd20: r = 34'sd1023;
            5'd21: r = 34'sd511;
            5'd22: r = 34'sd255;
            5'd23: r = 34'sd127;
            default: r = '0;
        endcase
        return r;
    endfunction

    // Q.30 product, rounded half up.
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd536870912;
        return 32'(p >>> 30);
    endfunction

    // Q.30 to Q16.16 with rounding.
    function automatic logic [31:0] to_q16(input logic signed [33:0] v);
        logic signed [33:0] t;
        t = v + 34'sd8192;
        return 32'(t >>> 14);
    endfunction

endpackage

FILE: rtl/ep2t_cordic.sv
// Pipelined sine/cosine for the three angles, one CORDIC step per stage.
module ep2t_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [31:0]   pos_x,
    input  logic signed [31:0]   pos_y,
    input  logic signed [31:0]   pos_z,
    input  logic signed [15:0]   angle_x,
    input  logic signed [15:0]   angle_y,
    input  logic signed [15:0]   angle_z,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ep2t_pkg::trig_t      out_data
);
    import ep2t_pkg::*;

    localparam int NS = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

    logic                 vld_reg [NS+1];
    logic signed [AW-1:0] x_reg [NS+1][3];
    logic signed [AW-1:0] y_reg [NS+1][3];
    logic signed [AW-1:0] z_reg [NS+1][3];
    logic                 neg_reg [NS+1][3];
    logic signed [31:0]   p_reg [NS+1][3];
    logic                 adv;
    logic signed [15:0]   ang [3];

    // Whole pipeline moves as one; it stalls only when its output is held.
    assign adv      = !vld_reg[NS] || out_ready;
    assign in_ready = adv;
    assign ang[0] = angle_x;
    assign ang[1] = angle_y;
    assign ang[2] = angle_z;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s <= NS; s++) vld_reg[s] <= 1'b0;
        end else if (adv) begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s <= NS; s++) vld_reg[s] <= vld_reg[s-1];
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [AW-1:0] z0;
        if (adv) begin
            p_reg[0][0] <= pos_x;
            p_reg[0][1] <= pos_y;
            p_reg[0][2] <= pos_z;
            for (int a = 0; a < 3; a++) begin
                z0 = AW'(ang[a]) <<< 17;
                x_reg[0][a] <= CORDIC_GAIN;
                y_reg[0][a] <= '0;
                if (z0 > Q30_HALF_PI) begin
                    z_reg[0][a] <= z0 - Q30_PI;
                    neg_reg[0][a] <= 1'b1;
                end else if (z0 < -Q30_HALF_PI) begin
                    z_reg[0][a] <= z0 + Q30_PI;
                    neg_reg[0][a] <= 1'b1;
                end else begin
                    z_reg[0][a] <= z0;
                    neg_reg[0][a] <= 1'b0;
                end
            end
            for (int s = 0; s < NS; s++) begin
                for (int a = 0; a < 3; a++) begin
                    p_reg[s+1][a]   <= p_reg[s][a];
                    neg_reg[s+1][a] <= neg_reg[s][a];
                    if (!z_reg[s][a][AW-1]) begin
                        x_reg[s+1][a] <= x_reg[s][a] - (y_reg[s][a] >>> s);
                        y_reg[s+1][a] <= y_reg[s][a] + (x_reg[s][a] >>> s);
                        z_reg[s+1][a] <= z_reg[s][a] - atan_lut(5'(s));
                    end else begin
                        x_reg[s+1][a] <= x_reg[s][a] + (y_reg[s][a] >>> s);
                        y_reg[s+1][a] <= y_reg[s][a] - (x_reg[s][a] >>> s);
                        z_reg[s+1][a] <= z_reg[s][a] + atan_lut(5'(s));
                    end
                end
            end
        end
    end

    function automatic logic signed [31:0] fin(input logic signed [AW-1:0] v,
                                               input logic n);
        logic signed [AW-1:0] t;
        t = n ? -v : v;
        if (t > Q30_ONE) t = Q30_ONE;
        else if (t < -Q30_ONE) t = -Q30_ONE;
        return 32'(t);
    endfunction

    assign out_valid   = vld_reg[NS];
    assign out_data.sx = fin(y_reg[NS][0], neg_reg[NS][0]);
    assign out_data.cx = fin(x_reg[NS][0], neg_reg[NS][0]);
    assign out_data.sy = fin(y_reg[NS][1], neg_reg[NS][1]);
    assign out_data.cy = fin(x_reg[NS][1], neg_reg[NS][1]);
    assign out_data.sz = fin(y_reg[NS][2], neg_reg[NS][2]);
    assign out_data.cz = fin(x_reg[NS][2], neg_reg[NS][2]);
    assign out_data.px = p_reg[NS][0];
    assign out_data.py = p_reg[NS][1];
    assign out_data.pz = p_reg[NS][2];
endmodule

FILE: rtl/ep2t_fifo.sv
// Short queue between the CORDIC front and the matrix back end.
module ep2t_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  ep2t_pkg::trig_t   in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ep2t_pkg::trig_t   out_data
);
    import ep2t_pkg::*;

    trig_t      mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_data  = mem_reg[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= in_data;
    end
endmodule

FILE: rtl/ep2t_matrix.sv
// Builds the transform: a product stage, a sum stage, then four output beats.
module ep2t_matrix (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  ep2t_pkg::trig_t     in_data,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_group_index,
    output logic signed [31:0]  m_elem_0,
    output logic signed [31:0]  m_elem_1,
    output logic signed [31:0]  m_elem_2,
    output logic signed [31:0]  m_elem_3,
    output logic                m_last_group
);
    import ep2t_pkg::*;

    // Stage 1: pairwise products.
    logic               v1_reg;
    logic signed [31:0] sxsy_reg, cxsy_reg, cxsz_reg, sxsz_reg, cxcz_reg, sxcz_reg;
    logic signed [31:0] cycz_reg, cysz_reg, sxcy_reg, cxcy_reg, sy1_reg, cz1_reg, sz1_reg;
    logic signed [31:0] p1_reg [3];
    // Stage 2: finished elements.
    logic               v2_reg;
    logic [31:0]        m_reg [12];
    logic signed [31:0] p2_reg [3];
    // Output beats.
    logic [1:0]         grp_reg;
    logic               adv1, adv2;

    assign adv2     = !v2_reg || (m_ready && grp_reg == 2'd3);
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            grp_reg <= '0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (v2_reg && m_ready) grp_reg <= grp_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            sxsy_reg <= qmul(in_data.sx, in_data.sy);
            cxsy_reg <= qmul(in_data.cx, in_data.sy);
            cxsz_reg <= qmul(in_data.cx, in_data.sz);
            sxsz_reg <= qmul(in_data.sx, in_data.sz);
            cxcz_reg <= qmul(in_data.cx, in_data.cz);
            sxcz_reg <= qmul(in_data.sx, in_data.cz);
            cycz_reg <= qmul(in_data.cy, in_data.cz);
            cysz_reg <= qmul(in_data.cy, in_data.sz);
            sxcy_reg <= qmul(in_data.sx, in_data.cy);
            cxcy_reg <= qmul(in_data.cx, in_data.cy);
            sy1_reg  <= in_data.sy;
            cz1_reg  <= in_data.cz;
            sz1_reg  <= in_data.sz;
            p1_reg[0] <= in_data.px;
            p1_reg[1] <= in_data.py;
            p1_reg[2] <= in_data.pz;
        end
        if (adv2) begin
            m_reg[0]  <= to_q16(34'(cycz_reg));
            m_reg[1]  <= to_q16(34'(qmul(sxsy_reg, cz1_reg)) + 34'(cxsz_reg));
            m_reg[2]  <= to_q16(-34'(qmul(cxsy_reg, cz1_reg)) + 34'(sxsz_reg));
            m_reg[3]  <= '0;
            m_reg[4]  <= to_q16(-34'(cysz_reg));
            m_reg[5]  <= to_q16(-34'(qmul(sxsy_reg, sz1_reg)) + 34'(cxcz_reg));
            m_reg[6]  <= to_q16(34'(qmul(cxsy_reg, sz1_reg)) + 34'(sxcz_reg));
            m_reg[7]  <= '0;
            m_reg[8]  <= to_q16(34'(sy1_reg));
            m_reg[9]  <= to_q16(-34'(sxcy_reg));
            m_reg[10] <= to_q16(34'(cxcy_reg));
            m_reg[11] <= '0;
            p2_reg <= p1_reg;
        end
    end

    always_comb begin
        m_elem_0 = '0; m_elem_1 = '0; m_elem_2 = '0; m_elem_3 = '0;
        case (grp_reg)
            2'd0: begin
                m_elem_0 = m_reg[0]; m_elem_1 = m_reg[1];
                m_elem_2 = m_reg[2]; m_elem_3 = m_reg[3];
            end
            2'd1: begin
                m_elem_0 = m_reg[4]; m_elem_1 = m_reg[5];
                m_elem_2 = m_reg[6]; m_elem_3 = m_reg[7];
            end
            2'd2: begin
                m_elem_0 = m_reg[8]; m_elem_1 = m_reg[9];
                m_elem_2 = m_reg[10]; m_elem_3 = m_reg[11];
            end
            default: begin
                m_elem_0 = p2_reg[0]; m_elem_1 = p2_reg[1];
                m_elem_2 = p2_reg[2]; m_elem_3 = 32'sd65536;
            end
        endcase
    end

    assign m_valid       = v2_reg;
    assign m_group_index = grp_reg;
    assign m_last_group  = grp_reg == 2'd3;
endmodule

FILE: rtl/euler_pose_to_transform_matrix_unit.sv
// Euler pose (Q16.16 position, Q3.13 radian angles) to a 4x4 homogeneous
// transform in Q16.16, sent as four beats of four elements, the last marked.
// A pose is accepted every cycle while the CORDIC pipeline is not stalled, into a CORDIC
// pipeline of CORDIC_STEPS steps (capped at 24) behind an input stage; the sustained rate
// is set by the four result beats per pose. The first beat is valid once the pose has
// passed the CORDIC pipeline, the queue and the product and sum stages. A two-entry queue
// separates the CORDIC front from the back end.
module euler_pose_to_transform_matrix_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [31:0]  s_pos_x,
    input  logic signed [31:0]  s_pos_y,
    input  logic signed [31:0]  s_pos_z,
    input  logic signed [15:0]  s_angle_x,
    input  logic signed [15:0]  s_angle_y,
    input  logic signed [15:0]  s_angle_z,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_group_index,
    output logic signed [31:0]  m_elem_0,
    output logic signed [31:0]  m_elem_1,
    output logic signed [31:0]  m_elem_2,
    output logic signed [31:0]  m_elem_3,
    output logic                m_last_group
);
    import ep2t_pkg::*;

    logic  c_valid, c_ready, q_valid, q_ready;
    trig_t c_data, q_data;

    ep2t_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .aclk, .aresetn,
        .in_valid(s_valid), .in_ready(s_ready),
        .pos_x(s_pos_x), .pos_y(s_pos_y), .pos_z(s_pos_z),
        .angle_x(s_angle_x), .angle_y(s_angle_y), .angle_z(s_angle_z),
        .out_valid(c_valid), .out_ready(c_ready), .out_data(c_data)
    );

    ep2t_fifo u_fifo (
        .aclk, .aresetn,
        .in_valid(c_valid), .in_ready(c_ready), .in_data(c_data),
        .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
    );

    ep2t_matrix u_matrix (
        .aclk, .aresetn,
        .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
        .m_valid, .m_ready, .m_group_index,
        .m_elem_0, .m_elem_1, .m_elem_2, .m_elem_3, .m_last_group
    );
endmodule

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEPS = 16;
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 60;

    localparam longint ATAN_Q30 [24] = '{
        843314856, 497837829, 263043836, 133525158,
        67021686, 33543515, 16775850, 8388437,
        4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767,
        16383, 8191, 4095, 2047,
        1023, 511, 255, 127
    };
    localparam longint ONE_Q30 = 1073741824;
    localparam longint PI_Q30 = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 1686629713;
    localparam longint GAIN_Q30 = 652032874;

    typedef struct {
        logic [31:0] px, py, pz;
        logic [15:0] ax, ay, az;
    } pose_t;

    typedef struct {
        logic [1:0]  grp;
        logic [31:0] e0, e1, e2, e3;
        logic        last;
    } group_t;

    class matrix_scoreboard;
        group_t expected_groups[$];
        int errors = 0;

        function automatic longint clamp_unit(longint v);
            if (v > ONE_Q30) return ONE_Q30;
            if (v < -ONE_Q30) return -ONE_Q30;
            return v;
        endfunction

        function automatic void sin_cos(input logic [15:0] a, output longint s,
                                        output longint c);
            longint z, x, y, dx, dy;
            bit neg;
            z = longint'($signed(a)) * 131072;
            x = GAIN_Q30;
            y = 0;
            neg = 0;
            if (z > HALF_PI_Q30) begin
                z -= PI_Q30;
                neg = 1;
            end else if (z < -HALF_PI_Q30) begin
                z += PI_Q30;
                neg = 1;
            end
            for (int i = 0; i < STEPS && i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= ATAN_Q30[i];
                end else begin
                    x += dx; y -= dy; z += ATAN_Q30[i];
                end
            end
            if (neg) begin
                x = -x;
                y = -y;
            end
            c = clamp_unit(x);
            s = clamp_unit(y);
        endfunction

        function automatic longint q30_mul(longint a, longint b);
            return (a * b + 536870912) >>> 30;
        endfunction

        function automatic logic [31:0] q30_to_q16(longint v);
            return 32'((v + 8192) >>> 14);
        endfunction

        function void note_pose(pose_t p);
            longint sx, cx, sy, cy, sz, cz;
            logic [31:0] m [16];
            group_t g;
            sin_cos(p.ax, sx, cx);
            sin_cos(p.ay, sy, cy);
            sin_cos(p.az, sz, cz);
            m[0] = q30_to_q16(q30_mul(cy, cz));
            m[1] = q30_to_q16(q30_mul(q30_mul(sx, sy), cz) + q30_mul(cx, sz));
            m[2] = q30_to_q16(-q30_mul(q30_mul(cx, sy), cz) + q30_mul(sx, sz));
            m[3] = '0;
            m[4] = q30_to_q16(-q30_mul(cy, sz));
            m[5] = q30_to_q16(-q30_mul(q30_mul(sx, sy), sz) + q30_mul(cx, cz));
            m[6] = q30_to_q16(q30_mul(q30_mul(cx, sy), sz) + q30_mul(sx, cz));
            m[7] = '0;
            m[8] = q30_to_q16(sy);
            m[9] = q30_to_q16(-q30_mul(sx, cy));
            m[10] = q30_to_q16(q30_mul(cx, cy));
            m[11] = '0;
            m[12] = p.px;
            m[13] = p.py;
            m[14] = p.pz;
            m[15] = 32'h0001_0000;
            for (int k = 0; k < 4; k++) begin
                g.grp = 2'(k);
                g.e0 = m[4*k];
                g.e1 = m[4*k+1];
                g.e2 = m[4*k+2];
                g.e3 = m[4*k+3];
                g.last = (k == 3);
                expected_groups.push_back(g);
            end
        endfunction

        function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %h, got %h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_group(group_t act);
            group_t exp_g;
            if (expected_groups.size() == 0) begin
                $error("unexpected result beat, group %0d", act.grp);
                errors++;
                return;
            end
            exp_g = expected_groups.pop_front();
            compare("group_index", 32'(exp_g.grp), 32'(act.grp));
            compare("elem_0", exp_g.e0, act.e0);
            compare("elem_1", exp_g.e1, act.e1);
            compare("elem_2", exp_g.e2, act.e2);
            compare("elem_3", exp_g.e3, act.e3);
            compare("last_group", 32'(exp_g.last), 32'(act.last));
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic signed [15:0] s_angle_x = '0, s_angle_y = '0, s_angle_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_group_index;
    logic signed [31:0] m_elem_0, m_elem_1, m_elem_2, m_elem_3;
    logic m_last_group;

    matrix_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit rx_hold = 0;
    int quiet_cycles = 0;

    euler_pose_to_transform_matrix_unit #(.CORDIC_STEPS(STEPS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .s_angle_x(s_angle_x), .s_angle_y(s_angle_y), .s_angle_z(s_angle_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_group_index(m_group_index),
        .m_elem_0(m_elem_0), .m_elem_1(m_elem_1),
        .m_elem_2(m_elem_2), .m_elem_3(m_elem_3),
        .m_last_group(m_last_group)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || rx_hold) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Both monitors sample the values that stood at the clock edge.
    always @(posedge aclk) begin
        pose_t p;
        group_t g;
        if (aresetn && s_valid && s_ready) begin
            p.px = s_pos_x; p.py = s_pos_y; p.pz = s_pos_z;
            p.ax = s_angle_x; p.ay = s_angle_y; p.az = s_angle_z;
            sb.note_pose(p);
        end
        if (aresetn && m_valid && m_ready) begin
            g.grp = m_group_index;
            g.e0 = m_elem_0; g.e1 = m_elem_1; g.e2 = m_elem_2; g.e3 = m_elem_3;
            g.last = m_last_group;
            sb.check_group(g);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Called right after a rising edge; returns right after the edge that took the beat.
    task automatic send_pose(pose_t p);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pos_x <= p.px; s_pos_y <= p.py; s_pos_z <= p.pz;
        s_angle_x <= p.ax; s_angle_y <= p.ay; s_angle_z <= p.az;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_angles(logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                               logic [31:0] pos);
        pose_t p;
        p.px = pos; p.py = ~pos; p.pz = pos ^ 32'h5A5A_A5A5;
        p.ax = ax; p.ay = ay; p.az = az;
        send_pose(p);
    endtask

    function automatic logic [15:0] random_angle();
        case ($urandom_range(3))
            0: return 16'($urandom_range(12869 + 8, 12869 - 8)
                          * ($urandom_range(1) ? 1 : -1));
            1: return 16'($signed(16'($urandom_range(25736 + 300, 25736 - 300)))
                          * ($urandom_range(1) ? 1 : -1));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random(int n);
        pose_t p;
        for (int i = 0; i < n; i++) begin
            p.px = $urandom; p.py = $urandom; p.pz = $urandom;
            p.ax = random_angle(); p.ay = random_angle(); p.az = random_angle();
            send_pose(p);
        end
    endtask

    task automatic wait_drained();
        while (sb.expected_groups.size() != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: zero, folds around plus and minus half pi, the extreme codes.
        send_angles(16'h0000, 16'h0000, 16'h0000, 32'h0000_0000);
        send_angles(16'h7FFF, 16'h8000, 16'h0000, 32'h7FFF_FFFF);
        send_angles(16'h8000, 16'h7FFF, 16'h7FFF, 32'h8000_0000);
        send_angles(16'd12867, 16'd12868, 16'd12869, 32'hFFFF_FFFF);
        send_angles(-16'sd12867, -16'sd12868, -16'sd12869, 32'h0001_0000);
        send_angles(16'd25736, -16'sd25736, 16'd6434, 32'hFFFF_0000);
        send_angles(16'h0001, 16'hFFFF, 16'h2000, 32'h0000_0001);
        send_angles(16'hE000, 16'h4000, 16'hC000, 32'h1234_5678);
        send_angles(16'h6488, 16'h9B78, 16'h3244, 32'hAAAA_AAAA);
        send_angles(16'h5555, 16'hAAAA, 16'h0000, 32'h5555_5555);
        send_angles(16'h0000, 16'h3244, 16'h0000, 32'h8000_0001);
        send_angles(16'h3244, 16'h0000, 16'hCDBC, 32'h7FFF_0000);

        send_idle_pct = 19;
        recv_idle_pct = 78;
        send_random(150);

        send_idle_pct = 78;
        recv_idle_pct = 19;
        send_random(140);

        // The sender stops until the whole backlog has drained.
        s_valid <= 1'b0;
        @(posedge aclk);
        wait_drained();

        // Receiver holds off while the sender keeps offering poses.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            begin
                rx_hold = 1;
                repeat (300) @(posedge aclk);
                rx_hold = 0;
            end
        join_none
        send_random(170);

        s_valid <= 1'b0;
        @(posedge aclk);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.expected_groups.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
